// File: design/dtpr_pkg.sv
package dtpr_pkg;

    // field widths
    localparam int SAMPLE_W  = 24;
    localparam int COEF_W    = 16;
    localparam int DELAY_W   = 7;
    localparam int IDX_W     = 8;
    localparam int FRAC_W    = 14;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = COEF_W;

    // structure
    localparam int FB_TAPS       = 2;
    localparam int MAX_DELAY_DEF = 128;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic        [DELAY_W-1:0]  delay_t;
    typedef logic        [IDX_W-1:0]    idx_t;

    localparam acc_t ROUND_HALF = acc_t'(2 ** (FRAC_W - 1));
    localparam acc_t SAT_HI     = acc_t'(2 ** (SAMPLE_W - 1) - 1);
    localparam acc_t SAT_LO     = acc_t'(-(2 ** (SAMPLE_W - 1)));
    localparam idx_t IDX_MAX    = idx_t'(2 ** IDX_W - 1);

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FB_ONE    = 2'd0,
        REG_FB_TWO    = 2'd1,
        REG_TAP_GAIN  = 2'd2,
        REG_TAP_DELAY = 2'd3
    } reg_index_t;

    // control handed to each feedback cell
    typedef struct packed {
        logic advance;
        logic clear;
    } cell_ctrl_t;

    // round half up from Q14, then clamp to the sample range
    function automatic sample_t round_sat(input acc_t v);
        acc_t r;
        r = (v + ROUND_HALF) >>> FRAC_W;
        if (r > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (r < SAT_LO)
        begin
            r = SAT_LO;
        end
        return $signed(r[SAMPLE_W-1:0]);
    endfunction

endpackage

// File: design/dtpr_if.sv
interface dtpr_in_if;
    import dtpr_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_in;
    logic    note_start;

    modport source (output valid, output sample_in, output note_start, input ready);
    modport sink   (input valid, input sample_in, input note_start, output ready);
endinterface

interface dtpr_out_if;
    import dtpr_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// File: design/dtpr_fb_cell.sv
module dtpr_fb_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  dtpr_pkg::cell_ctrl_t ctrl,
    input  dtpr_pkg::coef_t     coef,
    input  dtpr_pkg::sample_t   w_in,
    input  dtpr_pkg::acc_t      sum_in,
    output dtpr_pkg::sample_t   w_out,
    output dtpr_pkg::acc_t      sum_out
);
    import dtpr_pkg::*;

    sample_t held_reg;
    prod_t   prod;

    // held history value, zero at the first beat of a note
    assign w_out = ctrl.clear ? '0 : held_reg;

    // subtract this tap's share from the running sum
    assign prod    = prod_t'(coef) * prod_t'(w_out);
    assign sum_out = sum_in - ACC_W'(prod);

    // shift the history one cell along per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            held_reg <= w_in;
        end
    end

endmodule

// File: design/dtpr_ring_store.sv
module dtpr_ring_store #(
    parameter  int DEPTH  = dtpr_pkg::MAX_DELAY_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  dtpr_pkg::sample_t wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output dtpr_pkg::sample_t rd_data_a,
    output dtpr_pkg::sample_t rd_data_b
);
    import dtpr_pkg::*;

    sample_t mem [DEPTH];
    sample_t rd_a_reg;
    sample_t rd_b_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // two registered read ports, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// File: design/delayed_two_pole_resonator.sv
// Delayed two-pole resonator, one 24-bit audio sample per beat.
// excitation carries sample_in and note_start; response carries sample_out.
// Both are valid/ready channels; a beat moves when valid and ready are high.
// Coefficients a1, a2, b2 (Q2.14) and tap_delay are written through the
// cfg_we / cfg_index / cfg_wdata port; the user must write them only while
// no beat is in flight, which the block does not enforce. Throughput: one
// beat per cycle unless a stalled receiver has filled the pipeline. The
// resonator recurrence closes combinationally through a row of two
// feedback cells (one multiply each, chained). Stages: feedback row and
// history write, two-port registered read, tap sum into output register.
// Up to three beats are in flight; empty stages close up, so a stalled
// receiver only drops excitation ready once all three stages hold a beat.
// Reset clears the registers, the feedback cells, the note position, the
// ring position and the pipeline. The history store is not cleared: only
// entries written within the current note are ever read. Until the first
// note_start the block runs as if a note began at reset.
module delayed_two_pole_resonator #(
    parameter int MAX_DELAY = dtpr_pkg::MAX_DELAY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    dtpr_in_if.sink                       excitation,
    dtpr_out_if.source                    response,
    input  logic                          cfg_we,
    input  logic [dtpr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dtpr_pkg::CFG_W-1:0]    cfg_wdata
);
    import dtpr_pkg::*;

    localparam int ADDR_W = $clog2(MAX_DELAY);
    localparam int PW     = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 2;

    // configuration
    coef_t  a1_reg;
    coef_t  a2_reg;
    coef_t  b2_reg;
    delay_t delay_reg;
    delay_t ds;

    // handshake
    logic out_load;
    logic s2_free;
    logic s1_free;
    logic in_acc;

    // note position and ring position
    idx_t              idx_reg;
    idx_t              idx_cur;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] wr_addr;

    // feedback row
    cell_ctrl_t cell_ctrl;
    coef_t      fb_coef [FB_TAPS];
    sample_t    fb_w    [FB_TAPS+1];
    acc_t       fb_sum  [FB_TAPS+1];
    sample_t    w_new;

    // stage 1: read addresses
    logic              s1_valid_reg;
    idx_t              s1_idx_reg;
    logic [ADDR_W-1:0] s1_addr_a_reg;
    logic [ADDR_W-1:0] s1_addr_b_reg;
    logic signed [PW-1:0] diff_a;
    logic signed [PW-1:0] diff_b;

    // stage 2: history read
    logic    s2_valid_reg;
    idx_t    s2_idx_reg;
    sample_t w_tap;
    sample_t w_tap_old;

    // stage 3: output
    logic    out_valid_reg;
    sample_t out_data_reg;
    sample_t y_calc;
    prod_t   tap_prod;
    logic signed [IDX_W:0] m_calc;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_reg    <= '0;
            a2_reg    <= '0;
            b2_reg    <= '0;
            delay_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_FB_ONE:    a1_reg    <= $signed(cfg_wdata[COEF_W-1:0]);
                REG_FB_TWO:    a2_reg    <= $signed(cfg_wdata[COEF_W-1:0]);
                REG_TAP_GAIN:  b2_reg    <= $signed(cfg_wdata[COEF_W-1:0]);
                REG_TAP_DELAY: delay_reg <= cfg_wdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // delay limited to what the store can hold with the second tap
    always_comb
    begin
        if (int'(delay_reg) > MAX_DELAY - 3)
        begin
            ds = DELAY_W'(MAX_DELAY - 3);
        end
        else
        begin
            ds = delay_reg;
        end
    end

    // stage flow, empty stages close up
    assign out_load         = !out_valid_reg || response.ready;
    assign s2_free          = !s2_valid_reg || out_load;
    assign s1_free          = !s1_valid_reg || s2_free;
    assign excitation.ready = s1_free;
    assign in_acc           = excitation.valid && s1_free;

    // position of this beat within the note
    assign idx_cur = excitation.note_start ? '0 : idx_reg;
    assign wr_addr = (pos_reg == ADDR_W'(MAX_DELAY - 1)) ? '0 : pos_reg + ADDR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            pos_reg <= '0;
        end
        else if (in_acc)
        begin
            idx_reg <= (idx_cur == IDX_MAX) ? IDX_MAX : idx_cur + idx_t'(1);
            pos_reg <= wr_addr;
        end
    end

    // feedback row: w = round(x*2^14 - a1*w1 - a2*w2)
    assign cell_ctrl.advance = in_acc;
    assign cell_ctrl.clear   = excitation.note_start;
    assign fb_coef[0]        = a1_reg;
    assign fb_coef[1]        = a2_reg;
    assign fb_sum[0]         = ACC_W'(excitation.sample_in) <<< FRAC_W;
    assign fb_w[0]           = w_new;
    assign w_new             = round_sat(fb_sum[FB_TAPS]);

    for (genvar k = 0; k < FB_TAPS; k++)
    begin : g_fb
        dtpr_fb_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (cell_ctrl),
            .coef    (fb_coef[k]),
            .w_in    (fb_w[k]),
            .sum_in  (fb_sum[k]),
            .w_out   (fb_w[k+1]),
            .sum_out (fb_sum[k+1])
        );
    end

    // ring addresses of w[m] and w[m-2]
    always_comb
    begin
        diff_a = $signed(PW'(wr_addr)) - $signed(PW'(ds));
        if (diff_a < 0)
        begin
            diff_a = diff_a + PW'(MAX_DELAY);
        end
        diff_b = $signed(PW'(wr_addr)) - $signed(PW'(ds)) - PW'(2);
        if (diff_b < 0)
        begin
            diff_b = diff_b + PW'(MAX_DELAY);
        end
    end

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_idx_reg    <= idx_cur;
            s1_addr_a_reg <= diff_a[ADDR_W-1:0];
            s1_addr_b_reg <= diff_b[ADDR_W-1:0];
        end
    end

    // history store
    dtpr_ring_store #(
        .DEPTH (MAX_DELAY)
    ) u_store (
        .clk       (clk),
        .wr_en     (in_acc),
        .wr_addr   (wr_addr),
        .wr_data   (w_new),
        .rd_en     (s2_free && s1_valid_reg),
        .rd_addr_a (s1_addr_a_reg),
        .rd_addr_b (s1_addr_b_reg),
        .rd_data_a (w_tap),
        .rd_data_b (w_tap_old)
    );

    // stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_idx_reg <= s1_idx_reg;
        end
    end

    // output tap: silent early in the note, plain w[m] next, then the sum
    assign m_calc   = $signed((IDX_W+1)'(s2_idx_reg)) - $signed((IDX_W+1)'(ds));
    assign tap_prod = prod_t'(b2_reg) * prod_t'(w_tap_old);

    always_comb
    begin
        if (s2_idx_reg < idx_t'(2) || m_calc < 1)
        begin
            y_calc = '0;
        end
        else if (m_calc <= 2)
        begin
            y_calc = w_tap;
        end
        else
        begin
            y_calc = round_sat((ACC_W'(w_tap) <<< FRAC_W) + ACC_W'(tap_prod));
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= y_calc;
        end
    end

    assign response.valid      = out_valid_reg;
    assign response.sample_out = out_data_reg;

endmodule

// File: design/dtpr_checker.sv
module dtpr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input dtpr_pkg::sample_t out_data
);
    import dtpr_pkg::*;

    logic       in_beat;
    logic       out_beat;
    logic [2:0] outstanding_reg;
    logic [2:0] outstanding_next;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // beats taken in but not yet handed out
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_beat && !out_beat)
        begin
            outstanding_next = outstanding_reg + 3'd1;
        end
        else if (out_beat && !in_beat)
        begin
            outstanding_next = outstanding_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // a stalled response holds its beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("response changed while stalled");

    // never more beats in flight than the three stages hold
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd3)
        else $error("more beats in flight than pipeline stages");

    // no response without a beat behind it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> outstanding_reg != 3'd0)
        else $error("response without a pending beat");

    // into an empty pipeline the result passes the address, read and output registers before it shows
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && outstanding_reg == 3'd0 |-> ##3 out_valid)
        else $error("result late on an empty pipeline");

endmodule

bind delayed_two_pole_resonator dtpr_checker u_dtpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (excitation.valid),
    .in_ready  (excitation.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .out_data  (response.sample_out)
);

// File: sim/delayed_two_pole_resonator_tb.sv
module delayed_two_pole_resonator_tb;
    import dtpr_pkg::*;

    localparam int      STALL_LIMIT = 2000;
    localparam int      HOLD_CYCLES = 80;
    localparam int      RANDOM_BEATS = 900;
    localparam sample_t SAMPLE_TOP = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam sample_t SAMPLE_BOTTOM = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // expected response beats worked out from every accepted excitation beat
    class resonator_scoreboard;
        coef_t   fb_one;
        coef_t   fb_two;
        coef_t   tap_gain;
        delay_t  delay_reg;
        sample_t w_ring [MAX_DELAY_DEF];
        int      ring_pos;
        sample_t w_last;
        sample_t w_prior;
        idx_t    note_pos;
        sample_t tap_out_due [$];
        int      errors;
        int      checked;

        function new();
            fb_one    = '0;
            fb_two    = '0;
            tap_gain  = '0;
            delay_reg = '0;
            foreach (w_ring[i])
            begin
                w_ring[i] = '0;
            end
            ring_pos = 0;
            w_last   = '0;
            w_prior  = '0;
            note_pos = '0;
            errors   = 0;
            checked  = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [CFG_W-1:0] d);
            case (idx)
                REG_FB_ONE:    fb_one    = coef_t'(d);
                REG_FB_TWO:    fb_two    = coef_t'(d);
                REG_TAP_GAIN:  tap_gain  = coef_t'(d);
                REG_TAP_DELAY: delay_reg = d[DELAY_W-1:0];
                default:       ;
            endcase
        endfunction

        // q14 to sample: nearest, halves upward, then clamp
        function sample_t round_q14(longint v);
            longint r;
            r = (v + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
            if (r > longint'(SAMPLE_TOP))
            begin
                r = longint'(SAMPLE_TOP);
            end
            else if (r < longint'(SAMPLE_BOTTOM))
            begin
                r = longint'(SAMPLE_BOTTOM);
            end
            return sample_t'(r);
        endfunction

        function sample_t ring_back(int k);
            return w_ring[(ring_pos + MAX_DELAY_DEF - k) % MAX_DELAY_DEF];
        endfunction

        function int pending();
            return tap_out_due.size();
        endfunction

        function void note_input(sample_t x, logic start);
            int      ds;
            int      m;
            longint  acc;
            sample_t w;
            sample_t y;
            ds = int'(delay_reg);
            if (ds > MAX_DELAY_DEF - 3)
            begin
                ds = MAX_DELAY_DEF - 3;
            end
            // a new note wipes the resonator history
            if (start)
            begin
                foreach (w_ring[i])
                begin
                    w_ring[i] = '0;
                end
                w_last   = '0;
                w_prior  = '0;
                note_pos = '0;
            end
            // resonator recurrence
            acc = (longint'(x) <<< FRAC_W) - longint'(fb_one) * longint'(w_last)
                  - longint'(fb_two) * longint'(w_prior);
            w = round_q14(acc);
            ring_pos = (ring_pos + 1) % MAX_DELAY_DEF;
            w_ring[ring_pos] = w;
            // delayed output tap
            m = int'(note_pos) - ds;
            if (note_pos < 2 || m < 1)
            begin
                y = '0;
            end
            else if (m <= 2)
            begin
                y = ring_back(ds);
            end
            else
            begin
                y = round_q14((longint'(ring_back(ds)) <<< FRAC_W)
                              + longint'(tap_gain) * longint'(ring_back(ds + 2)));
            end
            tap_out_due.push_back(y);
            w_prior = w_last;
            w_last  = w;
            if (note_pos != IDX_MAX)
            begin
                note_pos++;
            end
        endfunction

        function void check_output(sample_t y);
            sample_t want;
            checked++;
            if (tap_out_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("response beat %0d not expected: sample_out=%0d", checked, y);
                end
                return;
            end
            want = tap_out_due.pop_front();
            if (y !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("response beat %0d: sample_out expected %0d, got %0d",
                             checked, want, y);
                end
            end
        endfunction

        function void check_drained();
            if (tap_out_due.size() != 0)
            begin
                errors++;
                $display("%0d response beats never arrived", tap_out_due.size());
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    dtpr_in_if  excitation_bus ();
    dtpr_out_if response_bus ();

    resonator_scoreboard sb;
    int   items_sent = 0;
    int   random_items = 0;
    int   note_left = 0;
    int   idle_cycles = 0;
    logic hold_request = 1'b0;

    delayed_two_pole_resonator #(
        .MAX_DELAY (MAX_DELAY_DEF)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .excitation (excitation_bus),
        .response   (response_bus),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // random field values
    function automatic sample_t pick_sample();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
        begin
            return sample_t'($urandom);
        end
        else if (sel < 70)
        begin
            return sample_t'(int'($urandom_range(0, 2000)) - 1000);
        end
        else if (sel < 85)
        begin
            return ($urandom_range(0, 1) == 1) ? SAMPLE_TOP : SAMPLE_BOTTOM;
        end
        return '0;
    endfunction

    function automatic logic [CFG_W-1:0] pick_coef();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
        begin
            return {1'b1, {(CFG_W-1){1'b0}}};
        end
        else if (sel < 20)
        begin
            return {1'b0, {(CFG_W-1){1'b1}}};
        end
        else if (sel < 25)
        begin
            return '0;
        end
        else if (sel < 60)
        begin
            return CFG_W'($urandom);
        end
        // moderate values, mostly decaying rings
        return CFG_W'(int'($urandom_range(0, 32000)) - 16000);
    endfunction

    function automatic logic [CFG_W-1:0] pick_delay();
        int               sel;
        logic [CFG_W-1:0] d;
        sel = $urandom_range(0, 99);
        if (sel < 35)
        begin
            d = CFG_W'($urandom_range(0, 4));
        end
        else if (sel < 60)
        begin
            d = CFG_W'($urandom_range(5, 20));
        end
        else if (sel < 85)
        begin
            d = CFG_W'($urandom_range(21, 100));
        end
        else
        begin
            d = CFG_W'($urandom_range(101, 127));
        end
        // unused upper bits must be ignored
        if ($urandom_range(0, 99) < 30)
        begin
            d[CFG_W-1:DELAY_W] = (CFG_W-DELAY_W)'($urandom_range(0, 511));
        end
        return d;
    endfunction

    function automatic int pick_note_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
        begin
            return $urandom_range(1, 40);
        end
        else if (sel < 90)
        begin
            return $urandom_range(41, 160);
        end
        return $urandom_range(256, 320);
    endfunction

    // one excitation beat, with random gaps outside the steady window
    task automatic send_beat(input sample_t x, input logic start);
        logic taken;
        while (!(items_sent >= 400 && items_sent < 560) && $urandom_range(0, 99) < 7)
        begin
            excitation_bus.valid <= 1'b0;
            @(posedge clk);
        end
        excitation_bus.valid      <= 1'b1;
        excitation_bus.sample_in  <= x;
        excitation_bus.note_start <= start;
        do
        begin
            @(negedge clk);
            taken = excitation_bus.ready;
            @(posedge clk);
        end
        while (!taken);
        items_sent++;
    endtask

    // stop sending and let every outstanding beat come back
    task automatic drain_responses();
        excitation_bus.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        sb.set_reg(idx, d);
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [CFG_W-1:0] a1, input logic [CFG_W-1:0] a2,
                                input logic [CFG_W-1:0] b2, input logic [CFG_W-1:0] dl);
        write_reg(REG_FB_ONE, a1);
        write_reg(REG_FB_TWO, a2);
        write_reg(REG_TAP_GAIN, b2);
        write_reg(REG_TAP_DELAY, dl);
        cfg_we <= 1'b0;
    endtask

    // handshake monitor and stall watchdog
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            idle_cycles++;
            if (excitation_bus.valid && excitation_bus.ready)
            begin
                sb.note_input(excitation_bus.sample_in, excitation_bus.note_start);
                idle_cycles = 0;
            end
            if (response_bus.valid && response_bus.ready)
            begin
                sb.check_output(response_bus.sample_out);
                idle_cycles = 0;
            end
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // response side: random back-pressure, one long hold-off on request
    initial
    begin
        response_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                response_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (sb.checked >= 420 && sb.checked < 580)
            begin
                response_bus.ready <= 1'b1;
            end
            else
            begin
                response_bus.ready <= ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // stimulus
    initial
    begin
        int   phase;
        int   len;
        logic start;
        sb = new();
        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_index                 <= REG_FB_ONE;
        cfg_wdata                 <= '0;
        excitation_bus.valid      <= 1'b0;
        excitation_bus.sample_in  <= '0;
        excitation_bus.note_start <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-up defaults, no note start seen yet
        send_beat(SAMPLE_TOP, 1'b0);
        send_beat(SAMPLE_BOTTOM, 1'b0);
        send_beat(sample_t'(1), 1'b0);
        send_beat(sample_t'(-1), 1'b0);
        send_beat('0, 1'b0);

        // extreme coefficients, saturating rings, no delay
        drain_responses();
        apply_config(16'h8000, 16'h7fff, 16'h7fff, 16'h0000);
        send_beat(SAMPLE_TOP, 1'b1);
        send_beat(SAMPLE_BOTTOM, 1'b0);
        send_beat(SAMPLE_TOP, 1'b0);
        send_beat('0, 1'b0);
        send_beat('0, 1'b0);
        send_beat('0, 1'b0);

        // opposite extremes, delay of one covers the plain taps
        drain_responses();
        apply_config(16'h7fff, 16'h8000, 16'h8000, 16'h0001);
        send_beat(SAMPLE_BOTTOM, 1'b1);
        send_beat(SAMPLE_TOP, 1'b0);
        send_beat(sample_t'(-1), 1'b0);
        send_beat(sample_t'(1), 1'b0);
        send_beat('0, 1'b0);
        send_beat('0, 1'b0);

        // delay past the store with upper bits set, restart within a note
        drain_responses();
        apply_config(16'h2000, 16'hf000, 16'h4000, 16'hff7f);
        send_beat(sample_t'(1000), 1'b1);
        send_beat('0, 1'b0);
        send_beat('0, 1'b0);
        send_beat(sample_t'(5000), 1'b1);
        send_beat('0, 1'b0);

        // random phases, notes may run across phases
        phase = 0;
        while (random_items < RANDOM_BEATS)
        begin
            drain_responses();
            apply_config(pick_coef(), pick_coef(), pick_coef(), pick_delay());
            len = (phase == 2) ? 150 : $urandom_range(30, 110);
            if (phase == 2)
            begin
                hold_request = 1'b1;
            end
            repeat (len)
            begin
                start = 1'b0;
                if (note_left == 0)
                begin
                    start     = 1'b1;
                    note_left = pick_note_len();
                end
                send_beat(pick_sample(), start);
                note_left--;
                random_items++;
            end
            phase++;
        end

        drain_responses();
        sb.check_drained();
        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/dtpr_pkg.sv
design/dtpr_if.sv
design/dtpr_fb_cell.sv
design/dtpr_ring_store.sv
design/delayed_two_pole_resonator.sv
design/dtpr_checker.sv
sim/delayed_two_pole_resonator_tb.sv
